FILE: src/linear_probe_hash_index_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear probing hash index
// Shared helpers that wrap a concurrent assertion with clock and reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_INDEX_ASSERT_SVH
`define LINEAR_PROBE_HASH_INDEX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPHI_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lphi assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LPHI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lphi assertion failed");

`endif

FILE: src/lphi_pkg.sv
// ----------------------------------------------------------------------------
// lphi_pkg
// Types and fixed constants of the linear probing hash index.
// ----------------------------------------------------------------------------
`default_nettype none

package lphi_pkg;

  // Width of the tag field and multiplier used by the home slot hash.
  localparam int unsigned TAG_BITS = 64;
  localparam logic [TAG_BITS-1:0] GOLDEN_MUL = 64'h9E37_79B9_7F4A_7C15;

  // New insertions stop once the entry count plus one reaches three quarters of the slot count.
  localparam int unsigned LOAD_NUM = 3;
  localparam int unsigned LOAD_DEN = 4;

  localparam int unsigned STATUS_BITS = 2;

  // Request modes.
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_PUT    = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_BAD_KEY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CMP,
    S_FINISH
  } state_e;

  // Commands from the sequencer to the probe address unit.
  typedef struct packed {
    logic load;
    logic step;
  } probe_ctrl_t;

endpackage

`default_nettype wire

FILE: src/lphi_req_if.sv
// ----------------------------------------------------------------------------
// lphi_req_if
// Request channel: operation mode, key, tag and value with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface lphi_req_if #(
  parameter int unsigned KEY_BITS   = 48,
  parameter int unsigned VALUE_BITS = 32
);
  import lphi_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [KEY_BITS-1:0]   key;
  logic [TAG_BITS-1:0]   tag;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, mode, key, tag, value, input ready);
  modport sink   (input valid, mode, key, tag, value, output ready);
endinterface

`default_nettype wire

FILE: src/lphi_rsp_if.sv
// ----------------------------------------------------------------------------
// lphi_rsp_if
// Result channel: found flag, stored value and status with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface lphi_rsp_if #(
  parameter int unsigned VALUE_BITS = 32
);
  import lphi_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [VALUE_BITS-1:0]  value_out;
  logic [STATUS_BITS-1:0] status;

  modport source (output valid, found, value_out, status, input ready);
  modport sink   (input valid, found, value_out, status, output ready);
endinterface

`default_nettype wire

FILE: src/lphi_store.sv
// ----------------------------------------------------------------------------
// lphi_store
// Slot memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lphi_store #(
  parameter int unsigned ADDR_BITS = 6,
  parameter int unsigned DATA_BITS = 144
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [DATA_BITS-1:0] wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [DATA_BITS-1:0] rdata_o
);
  localparam int unsigned Depth = 2 ** ADDR_BITS;

  logic [DATA_BITS-1:0] mem_q [Depth];
  logic [DATA_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/lphi_probe_addr.sv
// ----------------------------------------------------------------------------
// lphi_probe_addr
// Home slot hash and the stepping slot address of a linear probe.
// ----------------------------------------------------------------------------
`default_nettype none

module lphi_probe_addr #(
  parameter int unsigned SLOT_BITS = 6,
  parameter int unsigned KEY_BITS  = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lphi_pkg::probe_ctrl_t         ctrl_i,
  input  logic [KEY_BITS-1:0]           key_i,
  input  logic [lphi_pkg::TAG_BITS-1:0] tag_i,
  output logic [SLOT_BITS-1:0]          slot_o,
  output logic                          last_o
);
  import lphi_pkg::*;

  // Only the low slot bits of the 64-bit product reach the slot index.
  localparam logic [SLOT_BITS-1:0] GoldenLo = GOLDEN_MUL[SLOT_BITS-1:0];

  logic [63:0]          key_ext;
  logic [SLOT_BITS-1:0] tag_lo;
  logic [SLOT_BITS-1:0] prod;
  logic [SLOT_BITS-1:0] home;
  logic [SLOT_BITS-1:0] slot_q, slot_d;
  logic [SLOT_BITS-1:0] n_q, n_d;

  assign key_ext = 64'(key_i);
  assign tag_lo  = tag_i[SLOT_BITS-1:0];
  assign prod    = tag_lo * GoldenLo;
  assign home    = key_ext[SLOT_BITS+3:4] ^ prod;

  always_comb begin
    slot_d = slot_q;
    n_d    = n_q;
    if (ctrl_i.load) begin
      slot_d = home;
      n_d    = '0;
    end else if (ctrl_i.step) begin
      slot_d = slot_q + SLOT_BITS'(1);
      n_d    = n_q + SLOT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else begin
      n_q <= n_d;
    end
  end

  assign slot_o = slot_q;
  // The slot under compare is the last one of a full pass over the table.
  assign last_o = (n_q == '1);

endmodule

`default_nettype wire

FILE: src/linear_probe_hash_index.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_index
// Open addressing hash index from a nonzero key and a 64-bit tag to a value.
// Requests arrive on req_i (mode, key, tag, value) and each one gives exactly
// one result on rsp_o (found, value_out, status), in order. Mode zero looks a
// pair up; mode one updates a present pair or inserts a new one. The home
// slot is the key shifted right by four, XOR the tag times the golden ratio
// constant, cut to the slot count; probing steps one slot at a time.
// A request with a nonzero key goes through the hash, read and compare states
// before its result is loaded into the output register, and back to read
// and compare for every further slot, since each probe is a registered read
// of the slot memory followed by a compare. A zero key's result is loaded at
// the accepting edge when the output register is free, and offered in the
// next cycle. One request is in flight at a time; req_i.ready is high only
// while the sequencer is idle, so a new request is taken only once the last
// one is through.
// After reset a clearing pass writes every slot empty, with req_i.ready low.
// A finished result waits in the output register while rsp_o.ready is low.
// The sequencer may take the next request meanwhile, but holds that
// request's result, with req_i.ready low, until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "linear_probe_hash_index_assert.svh"

module linear_probe_hash_index #(
  parameter int unsigned SLOT_BITS  = 6,
  parameter int unsigned KEY_BITS   = 48,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lphi_req_if.sink   req_i,
  lphi_rsp_if.source rsp_o
);
  import lphi_pkg::*;

  localparam int unsigned SlotCount = 2 ** SLOT_BITS;
  localparam int unsigned EntryBits = KEY_BITS + TAG_BITS + VALUE_BITS;
  localparam int unsigned CntBits   = SLOT_BITS + 1;
  localparam int unsigned FullCount = (SlotCount * LOAD_NUM) / LOAD_DEN;
  // An insertion is refused once the count reaches this limit, one below FullCount.
  localparam logic [CntBits-1:0] FullLimit = CntBits'(FullCount - 1);

  state_e state_q, state_d;

  // Request under work.
  logic                  mode_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [TAG_BITS-1:0]   tag_q;
  logic [VALUE_BITS-1:0] val_q;

  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [SLOT_BITS-1:0] clr_q, clr_d;

  // Result parked while the output register is still occupied.
  logic                  res_found_q, res_found_d;
  logic [VALUE_BITS-1:0] res_value_q, res_value_d;
  status_e               res_status_q, res_status_d;

  logic                  out_valid_q, out_valid_d;
  logic                  out_found_q, out_found_d;
  logic [VALUE_BITS-1:0] out_value_q, out_value_d;
  status_e               out_status_q, out_status_d;

  logic                  done;
  logic                  done_found;
  logic [VALUE_BITS-1:0] done_value;
  status_e               done_status;

  logic                 mem_we;
  logic [SLOT_BITS-1:0] mem_waddr;
  logic [EntryBits-1:0] mem_wdata;
  logic [EntryBits-1:0] mem_rdata;
  logic [SLOT_BITS-1:0] slot;
  logic                 probe_last;
  probe_ctrl_t          probe_ctrl;

  logic [KEY_BITS-1:0]   e_key;
  logic [TAG_BITS-1:0]   e_tag;
  logic [VALUE_BITS-1:0] e_val;
  logic                  hit;
  logic                  empty;
  logic                  table_full;
  logic                  out_free;
  logic                  accept;

  lphi_probe_addr #(
    .SLOT_BITS (SLOT_BITS),
    .KEY_BITS  (KEY_BITS)
  ) u_probe_addr (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (probe_ctrl),
    .key_i  (key_q),
    .tag_i  (tag_q),
    .slot_o (slot),
    .last_o (probe_last)
  );

  lphi_store #(
    .ADDR_BITS (SLOT_BITS),
    .DATA_BITS (EntryBits)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (slot),
    .rdata_o (mem_rdata)
  );

  // A slot entry holds key, tag and value; a zero key marks it empty.
  assign e_key = mem_rdata[EntryBits-1 -: KEY_BITS];
  assign e_tag = mem_rdata[VALUE_BITS +: TAG_BITS];
  assign e_val = mem_rdata[VALUE_BITS-1:0];

  assign empty      = (e_key == '0);
  assign hit        = (e_key == key_q) && (e_tag == tag_q);
  assign table_full = (cnt_q >= FullLimit);
  assign out_free   = !out_valid_q || rsp_o.ready;
  assign accept     = req_i.valid && req_i.ready;

  assign req_i.ready     = (state_q == S_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.found     = out_found_q;
  assign rsp_o.value_out = out_value_q;
  assign rsp_o.status    = out_status_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    clr_d        = clr_q;
    res_found_d  = res_found_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_found_d  = out_found_q;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    mem_waddr    = slot;
    mem_wdata    = {key_q, tag_q, val_q};
    probe_ctrl   = '0;
    done         = 1'b0;
    done_found   = 1'b0;
    done_value   = '0;
    done_status  = STATUS_OK;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + SLOT_BITS'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.key == '0) begin
            done        = 1'b1;
            done_status = STATUS_BAD_KEY;
          end else begin
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        probe_ctrl.load = 1'b1;
        state_d         = S_READ;
      end
      S_READ: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (hit) begin
          done       = 1'b1;
          done_found = 1'b1;
          if (mode_q == MODE_LOOKUP) begin
            done_value = e_val;
          end else begin
            mem_we = 1'b1;
          end
        end else if (empty) begin
          done = 1'b1;
          if (mode_q == MODE_PUT) begin
            if (table_full) begin
              done_status = STATUS_FULL;
            end else begin
              mem_we = 1'b1;
              cnt_d  = cnt_q + CntBits'(1);
            end
          end
        end else if (probe_last) begin
          // A whole pass met only other pairs: a miss, and no room to insert.
          done = 1'b1;
          if (mode_q == MODE_PUT) begin
            done_status = STATUS_FULL;
          end
        end else begin
          probe_ctrl.step = 1'b1;
          state_d         = S_READ;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_found_d  = res_found_q;
          out_value_d  = res_value_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done) begin
      if (out_free) begin
        out_valid_d  = 1'b1;
        out_found_d  = done_found;
        out_value_d  = done_value;
        out_status_d = done_status;
        state_d      = S_IDLE;
      end else begin
        res_found_d  = done_found;
        res_value_d  = done_value;
        res_status_d = done_status;
        state_d      = S_FINISH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= req_i.mode;
      key_q  <= req_i.key;
      tag_q  <= req_i.tag;
      val_q  <= req_i.value;
    end
    res_found_q  <= res_found_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    out_found_q  <= out_found_d;
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

  // The load limit keeps the occupied slot count at or below the refusal point.
  `LPHI_ASSERT_IMPL(a_count_below_limit, clk_i, rst_ni, 1'b1, cnt_q <= FullLimit)

  // Outside the clearing pass, only a put in the compare step writes a slot.
  `LPHI_ASSERT_IMPL(a_write_only_put, clk_i, rst_ni, mem_we && state_q != S_CLEAR, mode_q == MODE_PUT && state_q == S_CMP)

  // A zero key's invalid key status is in the output register, or parked for it, in the next cycle.
  `LPHI_ASSERT_NEXT(a_zero_key_answer, clk_i, rst_ni, accept && req_i.key == '0, (out_valid_q && out_status_q == STATUS_BAD_KEY) || (state_q == S_FINISH && res_status_q == STATUS_BAD_KEY))

  // The entry count moves only in the compare step.
  `LPHI_ASSERT_NEXT(a_count_steady, clk_i, rst_ni, state_q != S_CMP, cnt_q == $past(cnt_q))

endmodule

`default_nettype wire

FILE: verif/linear_probe_hash_index_test.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_index_test
// Self-checking bench for the linear probing hash index. A short table of
// directed requests covers the field extremes, zero keys, updates and probe
// wraparound. A random phase then fills the table from a clustered pool of
// key and tag pairs, past the load limit, and mixes in lookups, near misses
// and noise. Every result is checked against a typed answer or a bench table model.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_index_test;
  import lphi_pkg::*;

  localparam int unsigned SLOT_BITS  = 6;
  localparam int unsigned KEY_BITS   = 48;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned SLOT_COUNT = 1 << SLOT_BITS;

  // Worst probe is a full pass: a registered read and a compare per slot.
  localparam int unsigned DRAIN_CYCLES = 4 + 2 * SLOT_COUNT + 32;
  // Generous bound on the whole run, clearing pass and stalls included.
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned POOL_SIZE    = 56;
  localparam int unsigned IDLE_PCT     = 17;

  localparam logic [KEY_BITS-1:0]   KMAX = '1;
  localparam logic [TAG_BITS-1:0]   TMAX = '1;
  localparam logic [VALUE_BITS-1:0] VMAX = '1;

  typedef struct packed {
    logic                  mode;
    logic [KEY_BITS-1:0]   key;
    logic [TAG_BITS-1:0]   tag;
    logic [VALUE_BITS-1:0] value;
  } request_t;

  typedef struct packed {
    logic                  found;
    logic [VALUE_BITS-1:0] value_out;
    status_e               status;
  } answer_t;

  // A directed row either carries an answer typed in by hand (typed = 1) or
  // leaves the answer to the table model.
  typedef struct packed {
    request_t req;
    logic     typed;
    answer_t  ans;
  } row_t;

  localparam answer_t ANS_MISS = '{1'b0, '0, STATUS_OK};
  localparam answer_t ANS_BAD  = '{1'b0, '0, STATUS_BAD_KEY};

  localparam int unsigned DIRECTED_ROWS = 21;

  // Rows 12 to 18 all hash to slot 63 with tag zero, so the probes after
  // row 12 wrap round to slot 0 and run into the entry placed by row 8 and
  // into each other; row 19 hashes to slot 1 and runs into rows 13 and 14.
  localparam row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{MODE_LOOKUP, 48'd1,     64'd0, 32'd0},        1'b1, ANS_MISS},
    '{'{MODE_PUT,    48'd0,     64'd0, VMAX},         1'b1, ANS_BAD},
    '{'{MODE_LOOKUP, 48'd0,     TMAX,  32'd0},        1'b1, ANS_BAD},
    '{'{MODE_PUT,    KMAX,      TMAX,  VMAX},         1'b1, ANS_MISS},
    '{'{MODE_LOOKUP, KMAX,      TMAX,  32'd0},        1'b1, '{1'b1, VMAX, STATUS_OK}},
    '{'{MODE_PUT,    KMAX,      TMAX,  32'd0},        1'b1, '{1'b1, '0, STATUS_OK}},
    '{'{MODE_LOOKUP, KMAX,      TMAX,  VMAX},         1'b1, '{1'b1, '0, STATUS_OK}},
    '{'{MODE_LOOKUP, KMAX,      64'd0, 32'd0},        1'b0, ANS_MISS},
    '{'{MODE_PUT,    48'd1,     64'd0, 32'd5},        1'b0, ANS_MISS},
    '{'{MODE_PUT,    48'd1,     64'd1, 32'd6},        1'b0, ANS_MISS},
    '{'{MODE_LOOKUP, 48'd1,     64'd0, 32'd0},        1'b0, ANS_MISS},
    '{'{MODE_LOOKUP, 48'd1,     64'd1, 32'd0},        1'b0, ANS_MISS},
    '{'{MODE_PUT,    48'h3F0,   64'd0, 32'h10},       1'b0, ANS_MISS},
    '{'{MODE_PUT,    48'h3F1,   64'd0, 32'h11},       1'b0, ANS_MISS},
    '{'{MODE_PUT,    48'h3F2,   64'd0, 32'h12},       1'b0, ANS_MISS},
    '{'{MODE_LOOKUP, 48'h3F2,   64'd0, 32'd0},        1'b0, ANS_MISS},
    '{'{MODE_LOOKUP, 48'h3F3,   64'd0, 32'd0},        1'b0, ANS_MISS},
    '{'{MODE_PUT,    48'h3F1,   64'd0, 32'hAAAA5555}, 1'b0, ANS_MISS},
    '{'{MODE_LOOKUP, 48'h3F1,   64'd0, 32'd0},        1'b0, ANS_MISS},
    '{'{MODE_PUT,    48'h010,   64'd0, 32'h20},       1'b0, ANS_MISS},
    '{'{MODE_LOOKUP, 48'h010,   64'd0, 32'd0},        1'b0, ANS_MISS}
  };

  logic clk;
  logic rst_n;

  lphi_req_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) req_bus ();
  lphi_rsp_if #(.VALUE_BITS(VALUE_BITS))                      rsp_bus ();

  linear_probe_hash_index #(
    .SLOT_BITS (SLOT_BITS),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  // Bench copy of the table. An empty slot holds key zero.
  bit [KEY_BITS-1:0]   slot_key [SLOT_COUNT];
  bit [TAG_BITS-1:0]   slot_tag [SLOT_COUNT];
  bit [VALUE_BITS-1:0] slot_val [SLOT_COUNT];
  int unsigned         entry_count;

  // Answers owed by the block, oldest first.
  answer_t     answer_q[$];
  int unsigned mismatches;
  int unsigned cycles;

  // While set, neither side of the bench inserts idle cycles.
  bit          steady;

  // Pairs used by the random phase. The key bits that feed the home slot are
  // squeezed into 16 values so that probe chains get long.
  logic [KEY_BITS-1:0] pool_key [POOL_SIZE];
  logic [TAG_BITS-1:0] pool_tag [POOL_SIZE];

  always #4 clk = ~clk;

  // Applies one accepted request to the bench table and returns its answer.
  task automatic index_access(input request_t r, output answer_t a);
    logic [TAG_BITS-1:0] h;
    int unsigned         s;
    int unsigned         n;
    bit                  hit;
    a = ANS_MISS;
    if (r.key == '0) begin
      a.status = STATUS_BAD_KEY;
      return;
    end
    h = (TAG_BITS'(r.key) >> 4) ^ (r.tag * GOLDEN_MUL);
    s = int'(h[SLOT_BITS-1:0]);
    // Walk forward, wrapping, to the matching slot or the first empty one.
    for (n = 0; n < SLOT_COUNT; n++) begin
      if (slot_key[s] == '0 || (slot_key[s] == r.key && slot_tag[s] == r.tag)) break;
      s = (s + 1) % SLOT_COUNT;
    end
    hit = (slot_key[s] == r.key) && (slot_tag[s] == r.tag);
    if (r.mode == MODE_LOOKUP) begin
      if (hit) begin
        a.found     = 1'b1;
        a.value_out = slot_val[s];
      end
    end else if (hit) begin
      a.found     = 1'b1;
      slot_val[s] = r.value;
    end else if ((entry_count + 1) * LOAD_DEN >= SLOT_COUNT * LOAD_NUM ||
                 slot_key[s] != '0) begin
      // A new pair past the load limit, or with no free slot on its path, is turned away.
      a.status = STATUS_FULL;
    end else begin
      slot_key[s] = r.key;
      slot_tag[s] = r.tag;
      slot_val[s] = r.value;
      entry_count++;
    end
  endtask

  // Offers one request, starting and ending at a falling edge. Idle cycles
  // come first, so valid never drops between back-to-back requests. The
  // answer is worked out at the rising edge that accepts the request.
  task automatic offer(input request_t r, input logic typed, input answer_t typed_ans);
    answer_t predicted;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      req_bus.valid = 1'b0;
      @(negedge clk);
    end
    req_bus.valid = 1'b1;
    req_bus.mode  = r.mode;
    req_bus.key   = r.key;
    req_bus.tag   = r.tag;
    req_bus.value = r.value;
    do @(posedge clk); while (!req_bus.ready);
    index_access(r, predicted);
    answer_q.push_back(typed ? typed_ans : predicted);
    @(negedge clk);
  endtask

  // Result side: stall at random, except during the steady stretch.
  always @(negedge clk) begin
    rsp_bus.ready = steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare every accepted result with the oldest owed answer.
  always @(posedge clk) begin
    answer_t a;
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result found=%0b value_out=%h status=%0d",
                 $time, rsp_bus.found, rsp_bus.value_out, rsp_bus.status);
        mismatches++;
      end else begin
        a = answer_q.pop_front();
        if (rsp_bus.found !== a.found || rsp_bus.value_out !== a.value_out ||
            rsp_bus.status !== a.status) begin
          $display("%0t: expected found=%0b value_out=%h status=%0d, got found=%0b value_out=%h status=%0d",
                   $time, a.found, a.value_out, a.status,
                   rsp_bus.found, rsp_bus.value_out, rsp_bus.status);
          mismatches++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("linear_probe_hash_index regression: fail");
      $finish;
    end
  end

  initial begin
    request_t    r;
    int unsigned i;
    int unsigned pick;
    int unsigned roll;
    clk           = 1'b0;
    rst_n         = 1'b0;
    steady        = 1'b0;
    mismatches    = 0;
    cycles        = 0;
    entry_count   = 0;
    req_bus.valid = 1'b0;
    req_bus.mode  = MODE_LOOKUP;
    req_bus.key   = '0;
    req_bus.tag   = '0;
    req_bus.value = '0;
    rsp_bus.ready = 1'b0;

    // Three tags share the pool; the key bits that feed the home slot take 16 values.
    for (i = 0; i < POOL_SIZE; i++) begin
      pool_key[i] = KEY_BITS'({$urandom, $urandom});
      pool_key[i][9:4] = 6'($urandom_range(15));
      if (pool_key[i] == '0) pool_key[i] = 48'd1;
      case ($urandom_range(2))
        0:       pool_tag[i] = '0;
        1:       pool_tag[i] = TMAX;
        default: pool_tag[i] = 64'h0123_4567_89AB_CDEF;
      endcase
    end

    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // The block runs its clearing pass first; the handshake absorbs it.
    for (i = 0; i < DIRECTED_ROWS; i++) begin
      offer(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].ans);
    end

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      // A stretch in the middle runs with no idling on either side.
      steady = (i >= 400 && i < 560);
      pick   = $urandom_range(POOL_SIZE - 1);
      roll   = $urandom_range(99);
      r.value = $urandom;
      // Lean on puts early so the table reaches its load limit.
      r.mode = ($urandom_range(99) < (i < 150 ? 80 : 45)) ? MODE_PUT : MODE_LOOKUP;
      if (roll < 72) begin
        r.key = pool_key[pick];
        r.tag = pool_tag[pick];
      end else if (roll < 84) begin
        // Near miss: a known key under a tag one bit away.
        r.key = pool_key[pick];
        r.tag = pool_tag[pick] ^ (64'd1 << $urandom_range(63));
      end else if (roll < 95) begin
        r.key = KEY_BITS'({$urandom, $urandom});
        r.tag = {$urandom, $urandom};
      end else begin
        r.key = '0;
        r.tag = {$urandom, $urandom};
      end
      offer(r, 1'b0, ANS_MISS);
    end
    steady        = 1'b0;
    req_bus.valid = 1'b0;

    while (answer_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("linear_probe_hash_index regression: pass");
    end else begin
      $display("linear_probe_hash_index regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: linear_probe_hash_index.f
+incdir+src
src/lphi_pkg.sv
src/lphi_req_if.sv
src/lphi_rsp_if.sv
src/lphi_store.sv
src/lphi_probe_addr.sv
src/linear_probe_hash_index.sv
verif/linear_probe_hash_index_test.sv
